// ----- hdl/bba_pkg.sv -----
// Shared types and codes for the buddy block allocator.
package bba_pkg;

  typedef enum logic [1:0] {
    ND_ABSENT = 2'd0,
    ND_FREE   = 2'd1,
    ND_SPLIT  = 2'd2,
    ND_ALLOC  = 2'd3
  } node_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_POOL_BASE = 2'd0,
    REG_MIN_SHIFT = 2'd1,
    REG_LEVELS    = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_ROUND,
    FS_SCAN_RD,
    FS_SCAN_CHK,
    FS_SPLIT_A,
    FS_SPLIT_B,
    FS_SPLIT_C,
    FS_MARK,
    FS_FREE_RD,
    FS_FREE_CHK,
    FS_FREE_MARK,
    FS_MERGE_RD,
    FS_MERGE_CHK,
    FS_MERGE_A,
    FS_MERGE_B
  } fsm_t;

  localparam int unsigned SHIFT_CAP = 16;
  localparam logic [47:0] POOL_BASE_RST = 48'd0;
  localparam logic [4:0]  MIN_SHIFT_RST = 5'd12;
  localparam logic [3:0]  LEVELS_RST    = 4'd11;

endpackage

// ----- hdl/buddy_block_allocator_top.sv -----
// Buddy allocator top level; the node tree lives in one synchronous memory.
// Allocate: round the size up by doublings, then scan nodes from the target level toward the
//   root (read, then check each), split down level by level, mark, then done for one cycle.
// Free: skip unaligned levels, probe aligned levels from the root down, mark the node free,
//   then merge with free buddies upward; an address outside the pool gives done the next cycle.
// One transaction at a time under busy, results cannot be stalled; reset or a shift or
//   levels write clears the tree with busy high.
module buddy_block_allocator_top #(
  parameter int MAX_LEVELS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [31:0] alloc_bytes,
  input  logic [47:0] address,
  output logic        done,
  output logic [1:0]  status,
  output logic [47:0] block_address,
  output logic [32:0] block_bytes,
  output logic [32:0] used_bytes,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int NODES = (1 << MAX_LEVELS) - 1;
  localparam int IW    = MAX_LEVELS;
  localparam int LW    = $clog2(MAX_LEVELS + 1);

  // configuration registers
  logic [47:0] pool_base;
  logic [4:0]  min_block_shift;
  logic [3:0]  level_count;

  // control and datapath registers
  bba_pkg::fsm_t state, state_next;
  logic [IW-1:0] clr;
  logic [IW-1:0] idx;
  logic [IW-1:0] p;
  logic [LW-1:0] d;
  logic [LW-1:0] target;
  logic [5:0]    e;
  logic [31:0]   req;
  logic [47:0]   rel;
  logic [32:0]   used;
  logic [32:0]   bytes;
  logic [1:0]    res_code;
  logic          fin;

  // tree memory
  bba_pkg::node_t mem [0:NODES-1];
  bba_pkg::node_t rdata;
  logic           mem_we;
  logic [IW-1:0]  mem_addr;
  bba_pkg::node_t mem_wdata;

  // derived geometry
  logic [4:0]    eff_shift;
  logic [LW-1:0] eff_lev;
  logic [5:0]    capexp;
  logic          cfg_wr;
  logic          geo_wr;
  logic [32:0]   size_now;
  logic          size_short;
  logic [IW-1:0] d_mask;
  logic          last_p;
  logic [5:0]    fex;
  logic [47:0]   fmask;
  logic          faligned;
  logic [IW-1:0] fidx;
  logic          flast;
  logic [IW-1:0] buddy;
  logic [IW-1:0] parent;
  logic [IW-1:0] idx_up;

  assign eff_shift = (min_block_shift > 5'(bba_pkg::SHIFT_CAP)) ?
                     5'(bba_pkg::SHIFT_CAP) : min_block_shift;
  assign eff_lev   = (level_count == 4'd0) ? LW'(1) :
                     (int'(level_count) > MAX_LEVELS) ? LW'(MAX_LEVELS) : LW'(level_count);
  assign capexp    = 6'(eff_shift) + 6'(eff_lev) - 6'd1;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign geo_wr = cfg_wr && (paddr[4:3] == bba_pkg::REG_MIN_SHIFT ||
                             paddr[4:3] == bba_pkg::REG_LEVELS);

  assign size_now   = 33'd1 << e;
  assign size_short = size_now < {1'b0, req};
  assign d_mask     = (IW'(1) << d) - IW'(1);
  assign last_p     = (p == d_mask);
  assign fex        = capexp - 6'(d);
  assign fmask      = (48'd1 << fex) - 48'd1;
  assign faligned   = (rel & fmask) == 48'd0;
  assign fidx       = d_mask + IW'(rel >> fex);
  assign flast      = (d == eff_lev - LW'(1));
  assign buddy      = idx[0] ? idx + IW'(1) : idx - IW'(1);
  assign parent     = (idx - IW'(1)) >> 1;
  assign idx_up     = (IW'(1) << (d - LW'(1))) - IW'(1);

  assign pready = 1'b1;
  assign busy   = (state != bba_pkg::FS_IDLE);

  // register readback
  always_comb begin
    case (paddr[4:3])
      bba_pkg::REG_POOL_BASE: prdata = {16'd0, pool_base};
      bba_pkg::REG_MIN_SHIFT: prdata = {59'd0, min_block_shift};
      bba_pkg::REG_LEVELS:    prdata = {60'd0, level_count};
      default:                prdata = 64'd0;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base       <= bba_pkg::POOL_BASE_RST;
      min_block_shift <= bba_pkg::MIN_SHIFT_RST;
      level_count     <= bba_pkg::LEVELS_RST;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        bba_pkg::REG_POOL_BASE: pool_base       <= pwdata[47:0];
        bba_pkg::REG_MIN_SHIFT: min_block_shift <= pwdata[4:0];
        bba_pkg::REG_LEVELS:    level_count     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // tree memory: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata <= mem[mem_addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= bba_pkg::FS_CLEAR;
    else     state <= state_next;
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = idx;
    mem_wdata  = bba_pkg::ND_ABSENT;
    fin        = 1'b0;
    case (state)
      bba_pkg::FS_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr;
        mem_wdata = (clr == '0) ? bba_pkg::ND_FREE : bba_pkg::ND_ABSENT;
        if (clr == IW'(NODES - 1)) state_next = bba_pkg::FS_IDLE;
      end
      bba_pkg::FS_IDLE: begin
        if (start) begin
          if (kind == bba_pkg::KIND_FREE) begin
            if ((address - pool_base) >= (48'd1 << capexp)) fin = 1'b1;
            else state_next = bba_pkg::FS_FREE_RD;
          end else begin
            state_next = bba_pkg::FS_ROUND;
          end
        end
      end
      bba_pkg::FS_ROUND: begin
        if (!size_short) begin
          if (e > capexp) begin
            fin        = 1'b1;
            state_next = bba_pkg::FS_IDLE;
          end else begin
            state_next = bba_pkg::FS_SCAN_RD;
          end
        end
      end
      bba_pkg::FS_SCAN_RD: state_next = bba_pkg::FS_SCAN_CHK;
      bba_pkg::FS_SCAN_CHK: begin
        if (rdata == bba_pkg::ND_FREE) begin
          state_next = (d < target) ? bba_pkg::FS_SPLIT_A : bba_pkg::FS_MARK;
        end else if (last_p && d == '0) begin
          fin        = 1'b1;
          state_next = bba_pkg::FS_IDLE;
        end else begin
          state_next = bba_pkg::FS_SCAN_RD;
        end
      end
      bba_pkg::FS_SPLIT_A: begin
        mem_we     = 1'b1;
        mem_wdata  = bba_pkg::ND_SPLIT;
        state_next = bba_pkg::FS_SPLIT_B;
      end
      bba_pkg::FS_SPLIT_B: begin
        mem_we     = 1'b1;
        mem_addr   = {idx[IW-2:0], 1'b0} + IW'(1);
        mem_wdata  = bba_pkg::ND_FREE;
        state_next = bba_pkg::FS_SPLIT_C;
      end
      bba_pkg::FS_SPLIT_C: begin
        mem_we     = 1'b1;
        mem_addr   = {idx[IW-2:0], 1'b0} + IW'(2);
        mem_wdata  = bba_pkg::ND_FREE;
        state_next = (d + LW'(1) < target) ? bba_pkg::FS_SPLIT_A : bba_pkg::FS_MARK;
      end
      bba_pkg::FS_MARK: begin
        mem_we     = 1'b1;
        mem_wdata  = bba_pkg::ND_ALLOC;
        fin        = 1'b1;
        state_next = bba_pkg::FS_IDLE;
      end
      bba_pkg::FS_FREE_RD: begin
        mem_addr = fidx;
        if (faligned) begin
          state_next = bba_pkg::FS_FREE_CHK;
        end else if (flast) begin
          fin        = 1'b1;
          state_next = bba_pkg::FS_IDLE;
        end
      end
      bba_pkg::FS_FREE_CHK: begin
        if (rdata == bba_pkg::ND_ALLOC) begin
          state_next = bba_pkg::FS_FREE_MARK;
        end else if (flast) begin
          fin        = 1'b1;
          state_next = bba_pkg::FS_IDLE;
        end else begin
          state_next = bba_pkg::FS_FREE_RD;
        end
      end
      bba_pkg::FS_FREE_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = bba_pkg::ND_FREE;
        if (idx == '0) begin
          fin        = 1'b1;
          state_next = bba_pkg::FS_IDLE;
        end else begin
          state_next = bba_pkg::FS_MERGE_RD;
        end
      end
      bba_pkg::FS_MERGE_RD: begin
        mem_addr   = buddy;
        state_next = bba_pkg::FS_MERGE_CHK;
      end
      bba_pkg::FS_MERGE_CHK: begin
        if (rdata != bba_pkg::ND_FREE) begin
          fin        = 1'b1;
          state_next = bba_pkg::FS_IDLE;
        end else begin
          mem_we     = 1'b1;
          mem_wdata  = bba_pkg::ND_ABSENT;
          state_next = bba_pkg::FS_MERGE_A;
        end
      end
      bba_pkg::FS_MERGE_A: begin
        mem_we     = 1'b1;
        mem_addr   = buddy;
        mem_wdata  = bba_pkg::ND_ABSENT;
        state_next = bba_pkg::FS_MERGE_B;
      end
      bba_pkg::FS_MERGE_B: begin
        mem_we    = 1'b1;
        mem_addr  = parent;
        mem_wdata = bba_pkg::ND_FREE;
        if (parent == '0) begin
          fin        = 1'b1;
          state_next = bba_pkg::FS_IDLE;
        end else begin
          state_next = bba_pkg::FS_MERGE_RD;
        end
      end
      default: state_next = bba_pkg::FS_IDLE;
    endcase
    // geometry change restarts the tree sweep
    if (geo_wr) state_next = bba_pkg::FS_CLEAR;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr  <= '0;
      done <= 1'b0;
    end else begin
      done <= fin;
      clr  <= (state == bba_pkg::FS_CLEAR && !geo_wr) ? clr + IW'(1) : '0;
      case (state)
        bba_pkg::FS_IDLE: begin
          req      <= alloc_bytes;
          rel      <= address - pool_base;
          e        <= 6'(eff_shift);
          d        <= '0;
          bytes    <= '0;
          res_code <= bba_pkg::ST_BAD_ADDR;
        end
        bba_pkg::FS_ROUND: begin
          if (size_short) begin
            e <= e + 6'd1;
          end else begin
            res_code <= (e > capexp) ? bba_pkg::ST_TOO_LARGE : bba_pkg::ST_NO_SPACE;
            target   <= LW'(capexp - e);
            d        <= LW'(capexp - e);
            p        <= '0;
            idx      <= (IW'(1) << LW'(capexp - e)) - IW'(1);
          end
        end
        bba_pkg::FS_SCAN_CHK: begin
          if (rdata != bba_pkg::ND_FREE) begin
            if (last_p) begin
              d   <= d - LW'(1);
              p   <= '0;
              idx <= idx_up;
            end else begin
              p   <= p + IW'(1);
              idx <= idx + IW'(1);
            end
          end
        end
        bba_pkg::FS_SPLIT_C: begin
          idx <= {idx[IW-2:0], 1'b0} + IW'(1);
          p   <= {p[IW-2:0], 1'b0};
          d   <= d + LW'(1);
        end
        bba_pkg::FS_MARK: begin
          bytes    <= size_now;
          res_code <= bba_pkg::ST_OK;
          rel      <= 48'(p) << e;
        end
        bba_pkg::FS_FREE_RD: begin
          idx <= fidx;
          if (!faligned) d <= d + LW'(1);
        end
        bba_pkg::FS_FREE_CHK: begin
          if (rdata != bba_pkg::ND_ALLOC) d <= d + LW'(1);
        end
        bba_pkg::FS_FREE_MARK: begin
          bytes    <= 33'd1 << fex;
          res_code <= bba_pkg::ST_OK;
        end
        bba_pkg::FS_MERGE_B: idx <= parent;
        default: ;
      endcase
    end
  end

  // running total of allocated bytes
  always_ff @(posedge clk) begin
    if (rst || geo_wr) used <= '0;
    else if (state == bba_pkg::FS_MARK) used <= used + size_now;
    else if (state == bba_pkg::FS_FREE_MARK) used <= used - (33'd1 << fex);
  end

  // result registers
  always_ff @(posedge clk) begin
    if (fin) begin
      if (state == bba_pkg::FS_IDLE) begin
        status        <= bba_pkg::ST_BAD_ADDR;
        block_address <= '0;
        block_bytes   <= '0;
      end else if (state == bba_pkg::FS_MARK) begin
        status        <= bba_pkg::ST_OK;
        block_address <= pool_base + (48'(p) << e);
        block_bytes   <= size_now;
      end else if (state == bba_pkg::FS_FREE_MARK) begin
        status        <= bba_pkg::ST_OK;
        block_address <= pool_base + rel;
        block_bytes   <= 33'd1 << fex;
      end else if (res_code == bba_pkg::ST_OK) begin
        status        <= res_code;
        block_address <= pool_base + rel;
        block_bytes   <= bytes;
      end else begin
        status        <= (state == bba_pkg::FS_ROUND && e > capexp) ?
                         bba_pkg::ST_TOO_LARGE : res_code;
        block_address <= '0;
        block_bytes   <= '0;
      end
    end
  end

  // used count follows the same edge as the tree update
  always_comb begin
    used_bytes = used;
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !fin) |=> busy)
    else $error("accepted request did not start work");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != bba_pkg::ST_OK) |-> (block_address == '0 && block_bytes == '0))
    else $error("error result carries a block");
`endif

endmodule
